// ----- rtl/vector_normalize_2d_3d_macros.svh -----
// Assertion macros for the vector normalizer.
`ifndef VECTOR_NORMALIZE_2D_3D_MACROS_SVH
`define VECTOR_NORMALIZE_2D_3D_MACROS_SVH
`ifndef SYNTHESIS
`define VN_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vn assertion failed");
`define VN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vn assertion failed");
`else
`define VN_ASSERT_IMPL(label, ante, cons)
`define VN_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/vn_pkg.sv -----
// Types and constants shared by the vector normalizer.
`default_nettype none
package vn_pkg;
  localparam int unsigned CompW   = 32;
  localparam int unsigned RootW   = 32;
  localparam int unsigned QuotW   = 17;
  localparam int unsigned RemW    = 34;
  localparam int unsigned RadW    = 64;
  localparam int unsigned NumLane = 3;

  typedef struct packed {
    logic              req_type;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } vn_in_t;

  typedef struct packed {
    logic signed [31:0] unit_x;
    logic signed [31:0] unit_y;
    logic signed [31:0] unit_z;
    logic [31:0]        vec_length;
    logic               zero_length;
  } vn_out_t;

  typedef struct packed {
    logic              valid;
    vn_in_t            item;
    logic [RadW-1:0]   rad;
    logic [RemW-1:0]   rem;
    logic [RootW-1:0]  root;
  } vn_sqrt_t;

  typedef struct packed {
    logic                          valid;
    vn_in_t                        item;
    logic [RootW-1:0]              len;
    logic [NumLane-1:0][QuotW-1:0] num;
    logic [NumLane-1:0][RootW-1:0] rem;
    logic [NumLane-1:0][QuotW-1:0] quot;
  } vn_div_t;

  function automatic logic [CompW-1:0] vn_mag(input logic [CompW-1:0] v);
    return v[CompW-1] ? (~v + 1'b1) : v;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/vn_sqrt_cell.sv -----
// One root bit of the square root chain.
`default_nettype none
module vn_sqrt_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire vn_pkg::vn_sqrt_t d_in,
  output vn_pkg::vn_sqrt_t      d_out
);
  import vn_pkg::*;
  logic [RemW+1:0] tmp;
  logic [RemW+1:0] trial;
  vn_sqrt_t        cell_r;
  vn_sqrt_t        cell_nxt;

  always_comb begin
    tmp      = {d_in.rem, d_in.rad[RadW-1 -: 2]};
    trial    = {2'b00, d_in.root, 2'b01};
    cell_nxt = d_in;
    cell_nxt.rad = {d_in.rad[RadW-3:0], 2'b00};
    if (tmp >= trial) begin
      cell_nxt.rem  = RemW'(tmp - trial);
      cell_nxt.root = {d_in.root[RootW-2:0], 1'b1};
    end else begin
      cell_nxt.rem  = tmp[RemW-1:0];
      cell_nxt.root = {d_in.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r.valid <= cell_nxt.valid;
    end
    if (en) begin
      cell_r.item <= cell_nxt.item;
      cell_r.rad  <= cell_nxt.rad;
      cell_r.rem  <= cell_nxt.rem;
      cell_r.root <= cell_nxt.root;
    end
  end

  assign d_out = cell_r;
endmodule
`default_nettype wire

// ----- rtl/vn_div_cell.sv -----
// One quotient bit of the three-lane divider chain.
`default_nettype none
module vn_div_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire vn_pkg::vn_div_t d_in,
  output vn_pkg::vn_div_t      d_out
);
  import vn_pkg::*;
  vn_div_t         cell_r;
  vn_div_t         cell_nxt;
  logic [RootW:0]  tmp [NumLane];

  always_comb begin
    cell_nxt = d_in;
    for (int i = 0; i < NumLane; i++) begin
      tmp[i] = {d_in.rem[i], d_in.num[i][QuotW-1]};
      cell_nxt.num[i] = {d_in.num[i][QuotW-2:0], 1'b0};
      if (tmp[i] >= {1'b0, d_in.len}) begin
        cell_nxt.rem[i]  = RootW'(tmp[i] - {1'b0, d_in.len});
        cell_nxt.quot[i] = {d_in.quot[i][QuotW-2:0], 1'b1};
      end else begin
        cell_nxt.rem[i]  = tmp[i][RootW-1:0];
        cell_nxt.quot[i] = {d_in.quot[i][QuotW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r.valid <= cell_nxt.valid;
    end
    if (en) begin
      cell_r.item <= cell_nxt.item;
      cell_r.len  <= cell_nxt.len;
      cell_r.num  <= cell_nxt.num;
      cell_r.rem  <= cell_nxt.rem;
      cell_r.quot <= cell_nxt.quot;
    end
  end

  assign d_out = cell_r;
endmodule
`default_nettype wire

// ----- rtl/vector_normalize_2d_3d.sv -----
// Vector normalizer top level: squares, root chain, divider chain, output.
//
// Input channel in_valid/in_ready/in_data carries one vector per item;
// req_type selects 3D (x,y,z) or 2D (x,y, z passed through).
// Output channel out_valid/out_ready/out_data returns the Q16.16 unit vector,
// the integer length and a zero-length flag, one result per item, in order.
// Pipeline: one stage of squares, one sum stage, 32 square-root cells
// (one root bit each), 17 divider cells (one quotient bit each, three lanes)
// and the output register.
// Throughput is one item per cycle while the output is not stalled; every cell holds one item.
// When the receiver holds out_ready low with a result waiting, the whole
// chain freezes and in_ready drops in the same cycle; items already in the
// chain are kept. Reset (rst_n low, synchronous) empties the chain.
// A zero length returns the input components unchanged with the flag set.
`default_nettype none
`include "vector_normalize_2d_3d_macros.svh"
module vector_normalize_2d_3d (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire vn_pkg::vn_in_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output vn_pkg::vn_out_t     out_data
);
  import vn_pkg::*;

  logic             adv;
  logic             s1_valid_r;
  vn_in_t           s1_item_r;
  logic [RadW-1:0]  sq_r [NumLane];
  vn_sqrt_t         sq_c [RootW+1];
  vn_div_t          dv_c [QuotW+1];
  logic [CompW-1:0] mag [NumLane];
  logic [CompW-1:0] raw [NumLane];
  logic [CompW-1:0] dmag [NumLane];
  logic [CompW-1:0] draw [NumLane];
  logic [CompW-1:0] unit [NumLane];
  vn_div_t          last;
  logic             out_valid_r;
  vn_out_t          out_r;
  vn_out_t          out_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  assign raw[0] = in_data.vec_x;
  assign raw[1] = in_data.vec_y;
  assign raw[2] = in_data.vec_z;

  always_comb begin
    for (int i = 0; i < NumLane; i++) begin
      mag[i] = vn_mag(raw[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
    if (adv) begin
      s1_item_r <= in_data;
      sq_r[0]   <= RadW'(mag[0]) * RadW'(mag[0]);
      sq_r[1]   <= RadW'(mag[1]) * RadW'(mag[1]);
      sq_r[2]   <= in_data.req_type ? '0 : RadW'(mag[2]) * RadW'(mag[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_c[0].valid <= 1'b0;
    end else if (adv) begin
      sq_c[0].valid <= s1_valid_r;
    end
    if (adv) begin
      sq_c[0].item <= s1_item_r;
      sq_c[0].rad  <= sq_r[0] + sq_r[1] + sq_r[2];
      sq_c[0].rem  <= '0;
      sq_c[0].root <= '0;
    end
  end

  for (genvar g = 0; g < RootW; g++) begin : g_sqrt
    vn_sqrt_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (adv),
      .d_in (sq_c[g]),
      .d_out(sq_c[g+1])
    );
  end

  assign draw[0] = sq_c[RootW].item.vec_x;
  assign draw[1] = sq_c[RootW].item.vec_y;
  assign draw[2] = sq_c[RootW].item.vec_z;

  always_comb begin
    for (int i = 0; i < NumLane; i++) begin
      dmag[i] = vn_mag(draw[i]);
    end
    dv_c[0].valid = sq_c[RootW].valid;
    dv_c[0].item  = sq_c[RootW].item;
    dv_c[0].len   = sq_c[RootW].root;
    for (int i = 0; i < NumLane; i++) begin
      dv_c[0].rem[i]  = {1'b0, dmag[i][CompW-1:1]};
      dv_c[0].num[i]  = {dmag[i][0], {(QuotW-1){1'b0}}};
      dv_c[0].quot[i] = '0;
    end
  end

  for (genvar g = 0; g < QuotW; g++) begin : g_div
    vn_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (adv),
      .d_in (dv_c[g]),
      .d_out(dv_c[g+1])
    );
  end

  assign last = dv_c[QuotW];

  always_comb begin
    unit[0] = last.item.vec_x[CompW-1] ? -CompW'(last.quot[0]) : CompW'(last.quot[0]);
    unit[1] = last.item.vec_y[CompW-1] ? -CompW'(last.quot[1]) : CompW'(last.quot[1]);
    unit[2] = last.item.vec_z[CompW-1] ? -CompW'(last.quot[2]) : CompW'(last.quot[2]);
    if (last.len == '0) begin
      out_nxt.unit_x      = last.item.vec_x;
      out_nxt.unit_y      = last.item.vec_y;
      out_nxt.unit_z      = last.item.vec_z;
      out_nxt.vec_length  = '0;
      out_nxt.zero_length = 1'b1;
    end else begin
      out_nxt.unit_x      = unit[0];
      out_nxt.unit_y      = unit[1];
      out_nxt.unit_z      = last.item.req_type ? last.item.vec_z : unit[2];
      out_nxt.vec_length  = last.len;
      out_nxt.zero_length = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last.valid;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `VN_ASSERT_IMPL(a_zero_len, out_valid && out_data.zero_length, out_data.vec_length == '0)
  `VN_ASSERT_IMPL(a_len_nz, out_valid && !out_data.zero_length, out_data.vec_length != '0)
  `VN_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule
`default_nettype wire
